/* sv/rsg_pkg.sv */
// Shared types and constants for the recording startup gate.
package rsg_pkg;

   localparam int unsigned REQ_TYPE_W = 4;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned INDEX_W    = 32;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ENC_READY     = 4'd0,
      REQ_WR_READY      = 4'd1,
      REQ_TAKE          = 4'd2,
      REQ_ARM           = 4'd3,
      REQ_DISARM        = 4'd4,
      REQ_TRY_START     = 4'd5,
      REQ_FIRST_FILE    = 4'd6,
      REQ_FRAME_WRITTEN = 4'd7,
      REQ_QUERY         = 4'd8
   } req_code_type;

   typedef enum logic [1:0] {
      PHASE_IDLE      = 2'd0,
      PHASE_ARMED     = 2'd1,
      PHASE_RECORDING = 2'd2
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_QUEUE_START_LEVEL = 2'd0,
      CSR_ARM_WAIT_MS       = 2'd1,
      CSR_SKIP_FRAMES       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] queue_start_level;
      logic [COUNT_W-1:0] arm_wait_ms;
      logic [COUNT_W-1:0] skip_frames;
   } cfg_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic                  take_value;
      logic [COUNT_W-1:0]    queue_depth;
      logic [STAMP_W-1:0]    now_ms;
      logic [INDEX_W-1:0]    frame_number;
   } item_type;

   typedef struct packed {
      logic       start_ok;
      logic       ignore_frame;
      logic       cadence_on;
      logic [1:0] phase_now;
   } result_type;

endpackage

/* sv/rsg_csr.sv */
// Configuration register file of the recording startup gate.
module rsg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [rsg_pkg::CSR_ADDR_W-1:0]      wr_index,
   input  logic [rsg_pkg::CSR_DATA_W-1:0]      wr_data,
   output rsg_pkg::cfg_type                    cfg
);

   rsg_pkg::cfg_type cfg_ff;
   rsg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            rsg_pkg::CSR_QUEUE_START_LEVEL: cfg_in.queue_start_level = wr_data;
            rsg_pkg::CSR_ARM_WAIT_MS:       cfg_in.arm_wait_ms       = wr_data;
            rsg_pkg::CSR_SKIP_FRAMES:       cfg_in.skip_frames       = wr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/rsg_core.sv */
// Phase and readiness state of the startup gate with its per-event update logic.
module rsg_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  rsg_pkg::item_type      item,
   input  rsg_pkg::cfg_type       cfg,
   output rsg_pkg::result_type    result
);

   rsg_pkg::phase_type               phase_ff, phase_in;
   logic                             encoder_ok_ff, encoder_ok_in;
   logic                             writer_ok_ff, writer_ok_in;
   logic                             take_ok_ff, take_ok_in;
   logic                             first_file_ff, first_file_in;
   logic                             cadence_ff, cadence_in;
   logic [rsg_pkg::COUNT_W-1:0]      written_ff, written_in;
   logic [rsg_pkg::STAMP_W-1:0]      arm_stamp_ff, arm_stamp_in;

   logic [rsg_pkg::STAMP_W-1:0]      elapsed;
   logic                             q_ready;
   logic                             t_ready;
   logic                             check_cadence;
   logic                             start_ok;
   logic                             ignore_frame;

   assign elapsed = item.now_ms - arm_stamp_ff;
   assign q_ready = item.queue_depth >= cfg.queue_start_level;
   assign t_ready = (cfg.arm_wait_ms == '0)
                    || (elapsed >= {{(rsg_pkg::STAMP_W-rsg_pkg::COUNT_W){1'b0}},
                                    cfg.arm_wait_ms});

   always_comb begin
      phase_in      = phase_ff;
      encoder_ok_in = encoder_ok_ff;
      writer_ok_in  = writer_ok_ff;
      take_ok_in    = take_ok_ff;
      first_file_in = first_file_ff;
      cadence_in    = cadence_ff;
      written_in    = written_ff;
      arm_stamp_in  = arm_stamp_ff;
      check_cadence = 1'b0;
      start_ok      = 1'b0;
      ignore_frame  = 1'b0;

      case (item.req_type)
         rsg_pkg::REQ_ENC_READY: begin
            encoder_ok_in = 1'b1;
            check_cadence = 1'b1;
         end
         rsg_pkg::REQ_WR_READY: begin
            writer_ok_in  = 1'b1;
            check_cadence = 1'b1;
         end
         rsg_pkg::REQ_TAKE: begin
            take_ok_in = item.take_value;
            if (!item.take_value) begin
               cadence_in    = 1'b0;
               first_file_in = 1'b0;
               written_in    = '0;
            end
            check_cadence = 1'b1;
         end
         rsg_pkg::REQ_ARM: begin
            phase_in      = rsg_pkg::PHASE_ARMED;
            arm_stamp_in  = item.now_ms;
            cadence_in    = 1'b0;
            first_file_in = 1'b0;
            written_in    = '0;
         end
         rsg_pkg::REQ_DISARM: begin
            phase_in      = rsg_pkg::PHASE_IDLE;
            cadence_in    = 1'b0;
            first_file_in = 1'b0;
            written_in    = '0;
            take_ok_in    = 1'b0;
         end
         rsg_pkg::REQ_TRY_START: begin
            if (phase_ff != rsg_pkg::PHASE_ARMED) begin
               start_ok = (phase_ff == rsg_pkg::PHASE_RECORDING);
            end else if (take_ok_ff && (q_ready || t_ready)) begin
               phase_in      = rsg_pkg::PHASE_RECORDING;
               cadence_in    = 1'b0;
               first_file_in = 1'b0;
               written_in    = '0;
               start_ok      = 1'b1;
            end
         end
         rsg_pkg::REQ_FIRST_FILE: begin
            first_file_in = 1'b1;
            check_cadence = 1'b1;
         end
         rsg_pkg::REQ_FRAME_WRITTEN: begin
            if (written_ff != {rsg_pkg::COUNT_W{1'b1}}) begin
               written_in = written_ff + 1'b1;
            end
            check_cadence = 1'b1;
         end
         rsg_pkg::REQ_QUERY: begin
            ignore_frame = item.frame_number
                           < {{(rsg_pkg::INDEX_W-rsg_pkg::COUNT_W){1'b0}},
                              cfg.skip_frames};
         end
         default: begin
            check_cadence = 1'b0;
         end
      endcase

      if (check_cadence && (phase_in == rsg_pkg::PHASE_RECORDING) && encoder_ok_in
          && writer_ok_in && take_ok_in && first_file_in
          && (written_in >= cfg.skip_frames)) begin
         cadence_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rsg_pkg::PHASE_IDLE;
         encoder_ok_ff <= 1'b0;
         writer_ok_ff  <= 1'b0;
         take_ok_ff    <= 1'b0;
         first_file_ff <= 1'b0;
         cadence_ff    <= 1'b0;
         written_ff    <= '0;
         arm_stamp_ff  <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         encoder_ok_ff <= encoder_ok_in;
         writer_ok_ff  <= writer_ok_in;
         take_ok_ff    <= take_ok_in;
         first_file_ff <= first_file_in;
         cadence_ff    <= cadence_in;
         written_ff    <= written_in;
         arm_stamp_ff  <= arm_stamp_in;
      end
   end

   assign result.start_ok     = start_ok;
   assign result.ignore_frame = ignore_frame;
   assign result.cadence_on   = cadence_in;
   assign result.phase_now    = phase_in;

endmodule

/* sv/recording_startup_gate_unit.sv */
// Top level of the recording startup gate: event and response streams, registers.
//
// Events enter on the req_ stream, one word per event: req_tuser carries the
// event code and req_tdata its arguments. Every event yields exactly one
// response word on the rsp_ stream, in order, reporting the start result,
// the frame-ignore answer, the cadence flag and the phase after the event.
// The csr_ channel writes the three configuration registers; it is always
// ready and should only be used while no events are in flight.
// An accepted event is held in an input register; the phase logic consumes it
// from there and the response is loaded into the output register, which then
// presents it on the rsp_ stream. One event per cycle is sustained while the
// receiver does not stall; the per-event update of the phase state sets this rate.
// If the receiver stalls, the output register holds its word and the input
// register can still take one more event before req_tready drops.
// Synchronous reset returns the gate to idle with all readiness flags,
// counters and configuration registers cleared and both streams empty.
module recording_startup_gate_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] take_value, [16:1] queue_depth, [48:17] now_ms, [80:49] frame_number
   input  logic [rsg_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [3:0] req_type
   input  logic [rsg_pkg::REQ_TYPE_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] start_ok, [1] ignore_frame, [2] cadence_on, [4:3] phase_now
   output logic [rsg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsg_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [rsg_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic                  in_valid_ff, in_valid_in;
   rsg_pkg::item_type     in_item_ff, in_item_in;
   logic                  out_valid_ff, out_valid_in;
   rsg_pkg::result_type   out_res_ff, out_res_in;
   rsg_pkg::result_type   core_res;
   rsg_pkg::cfg_type      cfg;
   logic                  advance;
   logic                  req_fire;

   assign csr_ready = 1'b1;

   rsg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   rsg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_res)
   );

   always_comb begin
      in_item_in              = in_item_ff;
      in_item_in.req_type     = req_tuser;
      in_item_in.take_value   = req_tdata[0];
      in_item_in.queue_depth  = req_tdata[16:1];
      in_item_in.now_ms       = req_tdata[48:17];
      in_item_in.frame_number = req_tdata[80:49];
      if (!req_fire) begin
         in_item_in = in_item_ff;
      end
      in_valid_in = req_fire || (in_valid_ff && !advance);
      out_res_in   = advance ? core_res : out_res_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_res_ff.phase_now, out_res_ff.cadence_on,
                        out_res_ff.ignore_frame, out_res_ff.start_ok};

   a_cadence_only_recording : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.cadence_on
      |-> out_res_ff.phase_now == rsg_pkg::PHASE_RECORDING)
      else $error("cadence reported outside the recording phase");

   a_start_ok_recording : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.start_ok
      |-> out_res_ff.phase_now == rsg_pkg::PHASE_RECORDING)
      else $error("start reported without recording phase");

   a_single_answer : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_res_ff.start_ok && out_res_ff.ignore_frame))
      else $error("start and ignore answers both set");

   a_hold_pending_event : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready
      |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending event lost while the response stalled");

endmodule

/* test/startup_gate_checker.sv */
`timescale 1ns / 1ps
// Watches the gate's channels, predicts every response word and compares it.
module startup_gate_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rsg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [rsg_pkg::REQ_TYPE_W-1:0] req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rsg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rsg_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [rsg_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count,
   output int                             start_count
);

   rsg_pkg::cfg_type            cfg;
   rsg_pkg::phase_type          gate_phase;
   logic                        enc_rdy;
   logic                        wr_rdy;
   logic                        take_rdy;
   logic                        first_file_seen;
   logic                        cadence;
   logic [rsg_pkg::COUNT_W-1:0] frames_written;
   logic [rsg_pkg::STAMP_W-1:0] armed_at;
   rsg_pkg::result_type         expected_words[$];

   function automatic void clear_progress();
      cadence         = 1'b0;
      first_file_seen = 1'b0;
      frames_written  = '0;
   endfunction

   function automatic void update_cadence();
      if (!cadence && gate_phase == rsg_pkg::PHASE_RECORDING && enc_rdy && wr_rdy &&
          take_rdy && first_file_seen && frames_written >= cfg.skip_frames)
         cadence = 1'b1;
   endfunction

   function automatic rsg_pkg::result_type gate_response(input rsg_pkg::item_type ev);
      rsg_pkg::result_type         r;
      logic [rsg_pkg::STAMP_W-1:0] elapsed;
      r = '0;
      case (ev.req_type)
         rsg_pkg::REQ_ENC_READY: begin
            enc_rdy = 1'b1;
            update_cadence();
         end
         rsg_pkg::REQ_WR_READY: begin
            wr_rdy = 1'b1;
            update_cadence();
         end
         rsg_pkg::REQ_TAKE: begin
            take_rdy = ev.take_value;
            if (!ev.take_value)
               clear_progress();
            update_cadence();
         end
         rsg_pkg::REQ_ARM: begin
            gate_phase = rsg_pkg::PHASE_ARMED;
            armed_at   = ev.now_ms;
            clear_progress();
         end
         rsg_pkg::REQ_DISARM: begin
            gate_phase = rsg_pkg::PHASE_IDLE;
            take_rdy   = 1'b0;
            clear_progress();
         end
         rsg_pkg::REQ_TRY_START: begin
            if (gate_phase != rsg_pkg::PHASE_ARMED) begin
               r.start_ok = (gate_phase == rsg_pkg::PHASE_RECORDING);
            end else begin
               // The elapsed time wraps with the 32-bit millisecond stamp.
               elapsed = ev.now_ms - armed_at;
               if (take_rdy && (ev.queue_depth >= cfg.queue_start_level ||
                                cfg.arm_wait_ms == '0 ||
                                elapsed >= {16'd0, cfg.arm_wait_ms})) begin
                  gate_phase = rsg_pkg::PHASE_RECORDING;
                  clear_progress();
                  r.start_ok = 1'b1;
               end
            end
         end
         rsg_pkg::REQ_FIRST_FILE: begin
            first_file_seen = 1'b1;
            update_cadence();
         end
         rsg_pkg::REQ_FRAME_WRITTEN: begin
            if (frames_written != '1)
               frames_written++;
            update_cadence();
         end
         rsg_pkg::REQ_QUERY: begin
            r.ignore_frame = (ev.frame_number < {16'd0, cfg.skip_frames});
         end
         default: begin
         end
      endcase
      r.cadence_on = cadence;
      r.phase_now  = gate_phase;
      return r;
   endfunction

   task automatic report_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsg_pkg::result_type want;
      rsg_pkg::result_type got;
      rsg_pkg::item_type   ev;
      rsg_pkg::phase_type  was;
      if (reset) begin
         cfg            = '0;
         gate_phase     = rsg_pkg::PHASE_IDLE;
         enc_rdy        = 1'b0;
         wr_rdy         = 1'b0;
         take_rdy       = 1'b0;
         armed_at       = '0;
         clear_progress();
         expected_words.delete();
         fail_count     = 0;
         pending_count  = 0;
         checked_count  = 0;
         start_count    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rsg_pkg::CSR_QUEUE_START_LEVEL: cfg.queue_start_level = csr_data;
               rsg_pkg::CSR_ARM_WAIT_MS:       cfg.arm_wait_ms       = csr_data;
               rsg_pkg::CSR_SKIP_FRAMES:       cfg.skip_frames       = csr_data;
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.start_ok     = rsp_tdata[0];
            got.ignore_frame = rsp_tdata[1];
            got.cadence_on   = rsp_tdata[2];
            got.phase_now    = rsp_tdata[4:3];
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected response word, expected none, got %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               report_field("start_ok", int'(want.start_ok), int'(got.start_ok));
               report_field("ignore_frame", int'(want.ignore_frame),
                            int'(got.ignore_frame));
               report_field("cadence_on", int'(want.cadence_on), int'(got.cadence_on));
               report_field("phase_now", int'(want.phase_now), int'(got.phase_now));
               report_field("padding", 0, int'(rsp_tdata[rsg_pkg::RSP_DATA_W-1:5]));
               checked_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            ev.req_type     = req_tuser;
            ev.take_value   = req_tdata[0];
            ev.queue_depth  = req_tdata[16:1];
            ev.now_ms       = req_tdata[48:17];
            ev.frame_number = req_tdata[80:49];
            was             = gate_phase;
            expected_words.push_back(gate_response(ev));
            if (was != rsg_pkg::PHASE_RECORDING && gate_phase == rsg_pkg::PHASE_RECORDING)
               start_count++;
         end
         pending_count = expected_words.size();
      end
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Top of the gate testbench: clock, reset, register settings, event stimulus and the verdict.
module testbench;

   localparam int unsigned CLOCK_HALF      = 2;
   localparam int unsigned RESET_CYCLES    = 5;
   localparam int unsigned RANDOM_PHASES   = 7;
   localparam int unsigned PHASE_EVENTS    = 260;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned DRAIN_LIMIT     = 5000;
   localparam longint      RUN_LIMIT_NS    = 20_000_000;

   localparam logic [rsg_pkg::CSR_ADDR_W-1:0] CSR_UNUSED      = 2'd3;
   localparam logic [rsg_pkg::REQ_TYPE_W-1:0] REQ_UNUSED_LOW  = 4'd9;
   localparam logic [rsg_pkg::REQ_TYPE_W-1:0] REQ_UNUSED_HIGH = 4'd15;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [rsg_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [rsg_pkg::REQ_TYPE_W-1:0] req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [rsg_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [rsg_pkg::CSR_ADDR_W-1:0] csr_index;
   logic [rsg_pkg::CSR_DATA_W-1:0] csr_data;

   int               fail_count;
   int               pending_count;
   int               checked_count;
   int               start_count;
   int               events_sent;
   int               settings_used;
   int               leftover;
   int               burst_left;
   bit               hold_off_req;
   bit               hold_off_taken;
   rsg_pkg::cfg_type cur_cfg;

   recording_startup_gate_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   startup_gate_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .start_count   (start_count)
   );

   initial clock = 1'b0;
   always #CLOCK_HALF clock = ~clock;

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run limit reached with %0d responses outstanding", $time, pending_count);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] near(input logic [31:0] v);
      return v + $urandom_range(0, 4) - 2;
   endfunction

   function automatic rsg_pkg::item_type make_event(
         input logic [rsg_pkg::REQ_TYPE_W-1:0] code);
      rsg_pkg::item_type it;
      it.req_type     = code;
      it.take_value   = 1'($urandom_range(0, 1));
      it.queue_depth  = 16'($urandom);
      it.now_ms       = $urandom;
      it.frame_number = $urandom;
      return it;
   endfunction

   // Called and returning at a falling edge; the sender may idle between bursts.
   task automatic send_event(input rsg_pkg::item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.req_type;
      req_tdata  <= {7'd0, it.frame_number, it.now_ms, it.queue_depth, it.take_value};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      events_sent++;
   endtask

   task automatic post(input logic [rsg_pkg::REQ_TYPE_W-1:0] code);
      send_event(make_event(code));
   endtask

   task automatic post_take(input logic level);
      rsg_pkg::item_type ev;
      ev = make_event(rsg_pkg::REQ_TAKE);
      ev.take_value = level;
      send_event(ev);
   endtask

   task automatic post_arm(input logic [rsg_pkg::STAMP_W-1:0] stamp);
      rsg_pkg::item_type ev;
      ev = make_event(rsg_pkg::REQ_ARM);
      ev.now_ms = stamp;
      send_event(ev);
   endtask

   task automatic post_try(input logic [rsg_pkg::COUNT_W-1:0] queued,
                           input logic [rsg_pkg::STAMP_W-1:0] stamp);
      rsg_pkg::item_type ev;
      ev = make_event(rsg_pkg::REQ_TRY_START);
      ev.queue_depth = queued;
      ev.now_ms      = stamp;
      send_event(ev);
   endtask

   task automatic post_query(input logic [rsg_pkg::INDEX_W-1:0] index);
      rsg_pkg::item_type ev;
      ev = make_event(rsg_pkg::REQ_QUERY);
      ev.frame_number = index;
      send_event(ev);
   endtask

   task automatic drain();
      int waited;
      req_tvalid <= 1'b0;
      burst_left = 0;
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_count != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, pending_count);
         leftover += pending_count;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The unused index is written last so that a stray decode would corrupt a live setting.
   task automatic program_settings(input logic [rsg_pkg::CSR_DATA_W-1:0] queue_level,
                                   input logic [rsg_pkg::CSR_DATA_W-1:0] wait_ms,
                                   input logic [rsg_pkg::CSR_DATA_W-1:0] skip_count);
      logic [rsg_pkg::CSR_ADDR_W-1:0] idx[4];
      logic [rsg_pkg::CSR_DATA_W-1:0] val[4];
      idx = '{rsg_pkg::CSR_QUEUE_START_LEVEL, rsg_pkg::CSR_ARM_WAIT_MS,
              rsg_pkg::CSR_SKIP_FRAMES, CSR_UNUSED};
      val = '{queue_level, wait_ms, skip_count, 16'($urandom)};
      csr_valid <= 1'b1;
      for (int k = 0; k < 4; k++) begin
         csr_index <= idx[k];
         csr_data  <= val[k];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      cur_cfg.queue_start_level = queue_level;
      cur_cfg.arm_wait_ms       = wait_ms;
      cur_cfg.skip_frames       = skip_count;
      settings_used++;
   endtask

   // One arm-to-record attempt with random content, aimed at the current thresholds.
   task automatic run_session();
      logic [rsg_pkg::STAMP_W-1:0] t0;
      logic [rsg_pkg::STAMP_W-1:0] offset;
      int                          frames;
      if ($urandom_range(0, 4) != 0) post(rsg_pkg::REQ_ENC_READY);
      if ($urandom_range(0, 4) != 0) post(rsg_pkg::REQ_WR_READY);
      t0 = $urandom;
      post_arm(t0);
      if ($urandom_range(0, 5) != 0) post_take(1'b1);
      repeat ($urandom_range(1, 4)) begin
         offset = $urandom_range(0, 1) ? near(32'(cur_cfg.arm_wait_ms)) :
                  $urandom_range(0, 32'(cur_cfg.arm_wait_ms) + 32'd1);
         post_try(16'(near(32'(cur_cfg.queue_start_level))), t0 + offset);
      end
      if ($urandom_range(0, 3) == 0) begin
         post_take(1'b1);
         post_try(16'(near(32'(cur_cfg.queue_start_level))),
                  t0 + near(32'(cur_cfg.arm_wait_ms)));
      end
      if ($urandom_range(0, 4) != 0) post(rsg_pkg::REQ_FIRST_FILE);
      frames = $urandom_range(0, 12);
      if (cur_cfg.skip_frames <= 40)
         frames += int'(cur_cfg.skip_frames);
      repeat (frames) begin
         post(rsg_pkg::REQ_FRAME_WRITTEN);
         if ($urandom_range(0, 6) == 0) post_query(near(32'(cur_cfg.skip_frames)));
      end
      if ($urandom_range(0, 2) == 0) post(rsg_pkg::REQ_ENC_READY);
      if ($urandom_range(0, 2) == 0) post(rsg_pkg::REQ_WR_READY);
      post_query($urandom_range(0, 1) ? near(32'(cur_cfg.skip_frames)) : $urandom);
      case ($urandom_range(0, 3))
         0: post_take(1'b0);
         1: post(rsg_pkg::REQ_DISARM);
         default: begin
         end
      endcase
   endtask

   // The receiver switches among four stall patterns, each held for a random run.
   initial begin
      int mode;
      int tick;
      rsp_tready = 1'b0;
      tick = 0;
      @(negedge clock);
      forever begin
         if (hold_off_req && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(4, 60)) begin
            tick++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (tick % 3 != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      int phase_start;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      events_sent    = 0;
      settings_used  = 0;
      leftover       = 0;
      burst_left     = 0;
      hold_off_req   = 1'b0;
      hold_off_taken = 1'b0;
      cur_cfg        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk: idle queries, a start across the stamp wrap, cadence, take loss,
      // unknown codes, disarm, a refused start and a start on queue depth.
      program_settings(16'd4, 16'd100, 16'd2);
      post_query(32'd0);
      post_try(16'hFFFF, 32'd0);
      post(rsg_pkg::REQ_ENC_READY);
      post(rsg_pkg::REQ_WR_READY);
      post_take(1'b1);
      post_arm(32'hFFFF_FFF0);
      post_try(16'd3, 32'h0000_0021);
      post_try(16'd3, 32'h0000_0054);
      post_try(16'd0, 32'd0);
      post(rsg_pkg::REQ_FIRST_FILE);
      post(rsg_pkg::REQ_FRAME_WRITTEN);
      post(rsg_pkg::REQ_FRAME_WRITTEN);
      post_query(32'd1);
      post_query(32'd2);
      post_query(32'hFFFF_FFFF);
      post_take(1'b0);
      post_take(1'b1);
      post(REQ_UNUSED_LOW);
      post(REQ_UNUSED_HIGH);
      post(rsg_pkg::REQ_DISARM);
      post_arm(32'd0);
      post_try(16'hFFFF, 32'hFFFF_FFFF);
      post_take(1'b1);
      post_try(16'd4, 32'd0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: program_settings(16'd0, 16'd0, 16'd0);
            1: program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: program_settings(16'd1, 16'd0, 16'd1);
            default: program_settings(16'($urandom_range(0, 6)),
                                      16'($urandom_range(0, 400)),
                                      16'($urandom_range(0, 20)));
         endcase
         if (p == 2)
            hold_off_req = 1'b1;
         phase_start = events_sent;
         while (events_sent - phase_start < PHASE_EVENTS) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 4)) post(4'($urandom_range(0, 15)));
            end else begin
               run_session();
            end
         end
         drain();
      end

      $display("Covered %0d events with %0d responses checked under %0d register settings.",
               events_sent, checked_count, settings_used);
      $display("Recording was entered %0d times, with one long receiver hold-off.",
               start_count);
      if (fail_count == 0 && leftover == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
